// File: hw/rtl/assert_macros.svh
// Assertion macros used by the controller (i2cs_ctrl) of the register slave.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/i2cs_pkg.sv
// Shared constants, types and lookup functions for the I2C register slave.
package i2cs_pkg;

    // Register file geometry
    localparam int NUM_REGS  = 64;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PTR_W     = 8;

    // Bus event codes
    typedef enum logic [1:0] {
        CMD_BEGIN    = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_RD_BEGIN = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    // Response status codes
    localparam logic STATUS_ACK  = 1'b0;
    localparam logic STATUS_NACK = 1'b1;

    // Device and register map
    localparam logic [6:0]       DEV_ADDRESS   = 7'h53;
    localparam logic [PTR_W-1:0] REG_POWER     = 8'h2D;
    localparam logic [PTR_W-1:0] REG_DATA_LO   = 8'h32;
    localparam logic [PTR_W-1:0] REG_DATA_HI   = 8'h37;
    localparam logic [7:0]       ID_VALUE      = 8'hE5;
    localparam int               MEASURE_BIT   = 3;
    localparam logic [15:0]      Z_LEVEL       = 16'd256;
    localparam logic [3:0]       QUARTER_SHIFT = 4'd4;

    // Snapshot sequencing: six data bytes, one per cycle
    localparam int SNAP_BYTES = 6;
    localparam int STEP_W     = $clog2(SNAP_BYTES);

    // Controller to datapath commands
    typedef struct packed {
        logic              accept;
        logic              load_read;
        logic              snap_we;
        logic [STEP_W-1:0] snap_step;
        logic              snap_done;
    } ctl_cmd_t;

    // Datapath to controller status (decode of the offered request)
    typedef struct packed {
        logic want_read;
        logic want_snap;
    } dp_stat_t;

    // 16-entry triangle wave, two's complement
    function automatic logic [15:0] tri_val(input logic [3:0] ph);
        logic [15:0] v;
        case (ph)
            4'd0:    v = 16'h0000;
            4'd1:    v = 16'h0004;
            4'd2:    v = 16'h0008;
            4'd3:    v = 16'h000C;
            4'd4:    v = 16'h0010;
            4'd5:    v = 16'h000C;
            4'd6:    v = 16'h0008;
            4'd7:    v = 16'h0004;
            4'd8:    v = 16'h0000;
            4'd9:    v = 16'hFFFC;
            4'd10:   v = 16'hFFF8;
            4'd11:   v = 16'hFFF4;
            4'd12:   v = 16'hFFF0;
            4'd13:   v = 16'hFFF4;
            4'd14:   v = 16'hFFF8;
            4'd15:   v = 16'hFFFC;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Byte of the little-endian X, Y, Z snapshot at a given offset
    function automatic logic [7:0] snap_byte(input logic [3:0] ph,
                                             input logic [STEP_W-1:0] step);
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  b;
        x = tri_val(ph);
        y = tri_val(ph + QUARTER_SHIFT);
        case (step)
            STEP_W'(0): b = x[7:0];
            STEP_W'(1): b = x[15:8];
            STEP_W'(2): b = y[7:0];
            STEP_W'(3): b = y[15:8];
            STEP_W'(4): b = Z_LEVEL[7:0];
            STEP_W'(5): b = Z_LEVEL[15:8];
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/i2cs_req_if.sv
// Request channel: one bus event per transfer.
interface i2cs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] data_byte;
    logic [7:0] read_len;

    modport source (output valid, output cmd, output dev_addr, output data_byte,
                    output read_len, input ready);
    modport sink   (input valid, input cmd, input dev_addr, input data_byte,
                    input read_len, output ready);
endinterface

// File: hw/rtl/i2cs_rsp_if.sv
// Response channel: status and read byte for each request.
interface i2cs_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

// File: hw/rtl/i2cs_ctrl.sv
// Controller: request handshake, response valid and snapshot sequencer.
`include "assert_macros.svh"

module i2cs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  i2cs_pkg::dp_stat_t  stat,
    output i2cs_pkg::ctl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SNAP = 3'b100
    } state_t;

    localparam logic [i2cs_pkg::STEP_W-1:0] STEP_LAST =
        i2cs_pkg::STEP_W'(i2cs_pkg::SNAP_BYTES - 1);

    state_t                       state_reg, state_next;
    logic [i2cs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         accept;

    // Take a request only when idle and the response register is free
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat.want_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                        if (stat.want_snap)
                        begin
                            state_next = ST_SNAP;
                            step_next  = '0;
                        end
                    end
                end
            end
            ST_READ:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SNAP:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Commands to the datapath
    always_comb
    begin
        ctl.accept    = accept;
        ctl.load_read = (state_reg == ST_READ);
        ctl.snap_we   = (state_reg == ST_SNAP);
        ctl.snap_step = step_reg;
        ctl.snap_done = (state_reg == ST_SNAP) && (step_reg == STEP_LAST);
    end

    // Read data lands in a response register that is already empty
    `ASSERT_IMPLY(a_read_rsp_free, clk, rst_n, state_reg == ST_READ, !rsp_valid_reg, "read response register busy")
    // A snapshot request starts the byte sequencer
    `ASSERT_NEXT(a_snap_start, clk, rst_n, accept && !stat.want_read && stat.want_snap, state_reg == ST_SNAP && step_reg == '0, "snapshot not started")
    // The sequencer ends after the last data byte
    `ASSERT_NEXT(a_snap_end, clk, rst_n, state_reg == ST_SNAP && step_reg == STEP_LAST, state_reg == ST_IDLE, "snapshot overran")

endmodule

// File: hw/rtl/i2cs_dp.sv
// Datapath: register file, pointer, bus state, wave phase and response payload.
module i2cs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          cmd,
    input  logic [6:0]          dev_addr,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          read_len,
    input  i2cs_pkg::ctl_cmd_t  ctl,
    output i2cs_pkg::dp_stat_t  stat,
    output logic                status,
    output logic [7:0]          read_data
);

    localparam int IW = i2cs_pkg::REG_IDX_W;
    localparam int PW = i2cs_pkg::PTR_W;
    localparam logic [PW:0] NUM_REGS_W = (PW + 1)'(i2cs_pkg::NUM_REGS);

    // Register file and per-entry written flags
    logic [7:0]                  mem_reg [i2cs_pkg::NUM_REGS];
    logic [i2cs_pkg::NUM_REGS-1:0] valid_reg;

    logic [PW-1:0] ptr_reg;
    logic [3:0]    phase_reg;
    logic          sel_reg;
    logic          pend_reg;
    logic          measure_reg;

    logic [7:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic          rd_range_reg;
    logic          rd_id_reg;
    logic          status_reg;
    logic [7:0]    read_data_reg;

    i2cs_pkg::cmd_t op;
    logic           ptr_in_range;
    logic [PW:0]    ptr_inc;
    logic [PW-1:0]  ptr_adv;
    logic [PW:0]    burst_end;
    logic           overlap;
    logic           addr_match;
    logic           host_we;
    logic           wr_en;
    logic [PW-1:0]  snap_addr;
    logic [IW-1:0]  wr_idx;
    logic [IW-1:0]  rd_idx;
    logic [7:0]     wr_data;
    logic [7:0]     rd_value;
    logic           nack;

    // Request decode
    assign op           = i2cs_pkg::cmd_t'(cmd);
    assign addr_match   = (dev_addr == i2cs_pkg::DEV_ADDRESS);
    assign ptr_in_range = ({1'b0, ptr_reg} < NUM_REGS_W);
    assign ptr_inc      = {1'b0, ptr_reg} + 1'b1;
    assign ptr_adv      = (ptr_inc >= NUM_REGS_W) ? '0 : ptr_inc[PW-1:0];
    assign burst_end    = {1'b0, ptr_reg} + {1'b0, read_len};
    assign overlap      = (read_len != 8'd0) && (ptr_reg <= i2cs_pkg::REG_DATA_HI)
                          && (burst_end > {1'b0, i2cs_pkg::REG_DATA_LO});

    assign stat.want_read = sel_reg && (op == i2cs_pkg::CMD_READ);
    assign stat.want_snap = sel_reg && (op == i2cs_pkg::CMD_RD_BEGIN) && overlap
                            && measure_reg;

    assign nack = (op == i2cs_pkg::CMD_BEGIN) ? !addr_match : !sel_reg;

    // Write port: host byte or snapshot byte
    assign host_we   = ctl.accept && sel_reg && (op == i2cs_pkg::CMD_WRITE) && !pend_reg
                       && ptr_in_range;
    assign wr_en     = host_we || ctl.snap_we;
    assign snap_addr = i2cs_pkg::REG_DATA_LO + PW'(ctl.snap_step);
    assign wr_idx    = ctl.snap_we ? snap_addr[IW-1:0] : ptr_reg[IW-1:0];
    assign wr_data   = ctl.snap_we ? i2cs_pkg::snap_byte(phase_reg, ctl.snap_step)
                                   : data_byte;
    assign rd_idx    = ptr_reg[IW-1:0];

    // Register file array, registered read at the pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        rd_data_reg  <= mem_reg[rd_idx];
        rd_valid_reg <= valid_reg[rd_idx];
        rd_range_reg <= ptr_in_range;
        rd_id_reg    <= (ptr_reg == '0);
    end

    // Unwritten entries read as their reset value
    always_comb
    begin
        if (!rd_range_reg)
        begin
            rd_value = 8'h00;
        end
        else if (rd_valid_reg)
        begin
            rd_value = rd_data_reg;
        end
        else if (rd_id_reg)
        begin
            rd_value = i2cs_pkg::ID_VALUE;
        end
        else
        begin
            rd_value = 8'h00;
        end
    end

    // Written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Bus state, pointer, measure shadow and wave phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            phase_reg   <= '0;
            sel_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            measure_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                case (op)
                    i2cs_pkg::CMD_BEGIN:
                    begin
                        sel_reg  <= addr_match;
                        pend_reg <= addr_match;
                    end
                    i2cs_pkg::CMD_WRITE:
                    begin
                        if (sel_reg)
                        begin
                            if (pend_reg)
                            begin
                                ptr_reg  <= data_byte;
                                pend_reg <= 1'b0;
                            end
                            else
                            begin
                                ptr_reg <= ptr_adv;
                            end
                        end
                    end
                    i2cs_pkg::CMD_RD_BEGIN:
                    begin
                        if (sel_reg)
                        begin
                            pend_reg <= 1'b0;
                        end
                    end
                    i2cs_pkg::CMD_READ:
                    begin
                        if (sel_reg)
                        begin
                            ptr_reg <= ptr_adv;
                        end
                    end
                    default:
                    begin
                        sel_reg <= sel_reg;
                    end
                endcase
            end
            if (host_we && (ptr_reg == i2cs_pkg::REG_POWER))
            begin
                measure_reg <= data_byte[i2cs_pkg::MEASURE_BIT];
            end
            if (ctl.snap_done)
            begin
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (ctl.load_read)
        begin
            status_reg    <= i2cs_pkg::STATUS_ACK;
            read_data_reg <= rd_value;
        end
        else if (ctl.accept)
        begin
            status_reg    <= nack ? i2cs_pkg::STATUS_NACK : i2cs_pkg::STATUS_ACK;
            read_data_reg <= 8'h00;
        end
    end

    assign status    = status_reg;
    assign read_data = read_data_reg;

endmodule

// File: hw/rtl/i2c_accel_register_slave.sv
// Byte-level I2C register slave at address 0x53 with an accelerometer data block.
// Each request is one bus event; each gives one response (status, read byte).
// Begin, write-byte and read-begin events are answered in the cycle after
// acceptance, so with the response taken at once one event is accepted per
// cycle. A read-byte event passes through the read state before its answer:
// the register file has one registered read port at the pointer. A read-begin
// that loads a measurement snapshot holds off new events while the six data
// bytes go one per cycle through the single write port; its response does not wait.
// The register file needs no clearing pass after reset: per-entry written
// flags make unwritten entries read as their reset value (0xE5 at entry 0).
module i2c_accel_register_slave (
    input  logic           clk,
    input  logic           rst_n,
    i2cs_req_if.sink       req,
    i2cs_rsp_if.source     rsp
);

    i2cs_pkg::ctl_cmd_t ctl;
    i2cs_pkg::dp_stat_t stat;

    // Sequencing and handshake
    i2cs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Storage and response payload
    i2cs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (req.cmd),
        .dev_addr  (req.dev_addr),
        .data_byte (req.data_byte),
        .read_len  (req.read_len),
        .ctl       (ctl),
        .stat      (stat),
        .status    (rsp.status),
        .read_data (rsp.read_data)
    );

endmodule
